// ===== src/mrfc_pkg.sv =====
package mrfc_pkg;

  localparam int LEN_W       = 3;
  localparam int KIND_W      = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [KIND_W-1:0] KIND_IDLE       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COUNT_DONE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CHIP       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FREQ       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CMD        = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONCE      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DUP        = 3'd6;
  localparam logic [KIND_W-1:0] KIND_IGNORED    = 3'd7;

  localparam logic [1:0] MODE_COUNT  = 2'd0;
  localparam logic [1:0] MODE_MINING = 2'd1;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_JOB_LIMIT = 2'd1;

  localparam logic [1:0]  MODE_RESET      = 2'd0;
  localparam logic [7:0]  JOB_LIMIT_RESET = 8'd31;

  localparam logic [4:0]  CRC_INIT   = 5'h1F;
  localparam logic [7:0]  CRC_MAX    = 8'h1F;
  localparam logic [7:0]  FREQ_REG   = 8'h80;
  localparam logic [7:0]  CHIP_REPLY = 8'h13;
  localparam logic [7:0]  JOB_XOR    = 8'h80;
  localparam logic [31:0] NONCE_ONES = 32'hFFFF_FFFF;
  localparam logic [7:0]  COUNT_MAX  = 8'hFF;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_SEEN = 2'd1,
    PHASE_DONE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SHIFT  = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

endpackage

// ===== src/miner_response_frame_classifier_core.sv =====
// Reply frame classifier for a hashing-chip serial link.
// Input channel: item_valid / item_stall carries one received frame (first
// byte in the top bits) and frame_length (0 is a read timeout, lengths above
// FRAME_BYTES count as FRAME_BYTES). A beat is taken when valid is high and
// stall is low; item_stall stays high while a frame is being worked on.
// Output channel: result_valid / result_stall carries one result per frame:
// kind, crc_ok, nonce_value, job_number, chip_total and first_duplicate.
// The CRC5 is computed one bit per cycle over 8*len-5 bits, so a frame of
// len bytes takes 8*len-4 cycles from its beat to its result (1 for a
// timeout), and the next frame may be taken the cycle after that.
// The result sits in an output register; a new frame is accepted while a
// result waits, but its result is held back until the waiting one is taken.
// Config: cfg_valid / cfg_ready writes mode (index 0) or job_limit (index 1),
// always ready; write only while no frame is in flight.
// Reset (rst, synchronous) empties the output, sets mode 0 and job_limit 31,
// and clears the chip count, counting phase, previous nonce and duplicate run.
module miner_response_frame_classifier_core #(
  parameter int FRAME_BYTES = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [8*FRAME_BYTES-1:0]            frame,
  input  logic [mrfc_pkg::LEN_W-1:0]          frame_length,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [mrfc_pkg::KIND_W-1:0]         kind,
  output logic                                crc_ok,
  output logic [31:0]                         nonce_value,
  output logic [7:0]                          job_number,
  output logic [7:0]                          chip_total,
  output logic                                first_duplicate,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mrfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int FW = 8 * FRAME_BYTES;
  localparam int CNT_W = $clog2(FW);
  localparam logic [3:0] FB_LEN = 4'(FRAME_BYTES);

  mrfc_pkg::state_t state;
  mrfc_pkg::phase_t count_phase, phase_next;

  logic [1:0]       mode;
  logic [7:0]       job_limit;
  logic [7:0]       chip_count, chip_next;
  logic [31:0]      prev_nonce, prev_next;
  logic [7:0]       duplicate_run, dup_next;

  logic [FW-1:0]    data;
  logic [FW-1:0]    shreg;
  logic [3:0]       len;
  logic [CNT_W-1:0] cnt;
  logic [4:0]       crc;
  logic [4:0]       crc_step;

  logic [3:0]       len_sat;
  logic [FW-1:0]    frame_masked;
  logic [6:0]       nbits_full;
  logic             item_accept;
  logic             result_load;

  logic [63:0]      wide;
  logic [7:0]       bval [8];
  logic [2:0]       last_idx;
  logic [7:0]       last_byte;
  logic [31:0]      nonce;
  logic [7:0]       job;

  logic [mrfc_pkg::KIND_W-1:0] kind_c;
  logic             ok_c;
  logic [31:0]      nonce_c;
  logic [7:0]       job_c;
  logic             first_c;

  assign item_stall  = (state != mrfc_pkg::ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign cfg_ready   = 1'b1;
  assign result_load = (state == mrfc_pkg::ST_FINISH) && (!result_valid || !result_stall);

  assign len_sat = ({1'b0, frame_length} > FB_LEN) ? FB_LEN : {1'b0, frame_length};
  assign nbits_full = {len_sat, 3'b000} - 7'd5;

  // zero the bytes past the frame length
  always_comb begin
    frame_masked = '0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (4'(i) < len_sat) begin
        frame_masked[FW-8-8*i +: 8] = frame[FW-8-8*i +: 8];
      end
    end
  end

  // x^5+x^2+1, msb first
  always_comb begin
    logic n0;
    n0 = crc[4] ^ shreg[FW-1];
    crc_step = {crc[3], crc[2], crc[1] ^ n0, crc[0], n0};
  end

  assign wide = 64'(data) << (64 - FW);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bval[i] = wide[63-8*i -: 8];
    end
  end

  assign last_idx  = 3'(len - 4'd1);
  assign last_byte = bval[last_idx];
  assign nonce     = {bval[0], bval[1], bval[2], bval[3]};
  assign job       = bval[4] ^ mrfc_pkg::JOB_XOR;

  always_comb begin
    kind_c     = mrfc_pkg::KIND_IDLE;
    ok_c       = 1'b0;
    nonce_c    = '0;
    job_c      = '0;
    first_c    = 1'b0;
    chip_next  = chip_count;
    phase_next = count_phase;
    prev_next  = prev_nonce;
    dup_next   = duplicate_run;
    if (len == 4'd0) begin
      if (mode == mrfc_pkg::MODE_COUNT && count_phase == mrfc_pkg::PHASE_SEEN) begin
        phase_next = mrfc_pkg::PHASE_DONE;
        kind_c     = mrfc_pkg::KIND_COUNT_DONE;
      end
    end else begin
      ok_c = (last_byte <= mrfc_pkg::CRC_MAX) && ({3'b000, crc} == last_byte);
      if (ok_c) begin
        if (bval[0] == mrfc_pkg::FREQ_REG) begin
          kind_c = mrfc_pkg::KIND_FREQ;
        end else if (mode == mrfc_pkg::MODE_COUNT && count_phase != mrfc_pkg::PHASE_DONE
                     && bval[0] == mrfc_pkg::CHIP_REPLY) begin
          if (chip_count != mrfc_pkg::COUNT_MAX) begin
            chip_next = chip_count + 8'd1;
          end
          phase_next = mrfc_pkg::PHASE_SEEN;
          kind_c     = mrfc_pkg::KIND_CHIP;
        end else begin
          kind_c = mrfc_pkg::KIND_CMD;
        end
      end else if (mode == mrfc_pkg::MODE_MINING) begin
        if (nonce == '0 || nonce == mrfc_pkg::NONCE_ONES || job >= job_limit) begin
          kind_c = mrfc_pkg::KIND_IGNORED;
        end else if (nonce == prev_nonce) begin
          if (duplicate_run != mrfc_pkg::COUNT_MAX) begin
            dup_next = duplicate_run + 8'd1;
          end
          first_c = (dup_next == 8'd1);
          kind_c  = mrfc_pkg::KIND_DUP;
          nonce_c = nonce;
          job_c   = job;
        end else begin
          dup_next  = '0;
          prev_next = nonce;
          kind_c    = mrfc_pkg::KIND_NONCE;
          nonce_c   = nonce;
          job_c     = job;
        end
      end else begin
        kind_c = mrfc_pkg::KIND_IGNORED;
      end
    end
  end

  // sequencer and bit-serial crc
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrfc_pkg::ST_IDLE;
    end else begin
      case (state)
        mrfc_pkg::ST_IDLE: begin
          if (item_accept) begin
            state <= (len_sat == 4'd0) ? mrfc_pkg::ST_FINISH : mrfc_pkg::ST_SHIFT;
          end
        end
        mrfc_pkg::ST_SHIFT: begin
          if (cnt == CNT_W'(1)) begin
            state <= mrfc_pkg::ST_FINISH;
          end
        end
        mrfc_pkg::ST_FINISH: begin
          if (result_load) begin
            state <= mrfc_pkg::ST_IDLE;
          end
        end
        default: state <= mrfc_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      data  <= frame_masked;
      shreg <= frame_masked;
      len   <= len_sat;
      crc   <= mrfc_pkg::CRC_INIT;
      cnt   <= CNT_W'(nbits_full);
    end else if (state == mrfc_pkg::ST_SHIFT) begin
      crc   <= crc_step;
      shreg <= shreg << 1;
      cnt   <= cnt - CNT_W'(1);
    end
  end

  // classifier state and config
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= mrfc_pkg::MODE_RESET;
      job_limit     <= mrfc_pkg::JOB_LIMIT_RESET;
      chip_count    <= '0;
      count_phase   <= mrfc_pkg::PHASE_IDLE;
      prev_nonce    <= '0;
      duplicate_run <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mrfc_pkg::CFG_MODE:      mode <= cfg_data[1:0];
          mrfc_pkg::CFG_JOB_LIMIT: job_limit <= cfg_data;
          default: ;
        endcase
      end
      if (result_load) begin
        chip_count    <= chip_next;
        count_phase   <= phase_next;
        prev_nonce    <= prev_next;
        duplicate_run <= dup_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      kind            <= kind_c;
      crc_ok          <= ok_c;
      nonce_value     <= nonce_c;
      job_number      <= job_c;
      chip_total      <= chip_next;
      first_duplicate <= first_c;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] MODE_CLASSIFY     = 2'd2;
  localparam logic [1:0] MODE_CLASSIFY_ALT = 2'd3;
  localparam logic [mrfc_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [mrfc_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [mrfc_pkg::KIND_W-1:0] kind;
    logic              crc_ok;
    logic [31:0]       nonce;
    logic [7:0]        job;
    logic [7:0]        total;
    logic              first_dup;
  } reply_t;

  typedef enum {MIX_CHIPS, MIX_CHIPS_END, MIX_MINING, MIX_DUPS, MIX_ANY} mix_t;
  typedef enum {
    ACT_CHIP, ACT_FREQ, ACT_OTHER, ACT_TIMEOUT, ACT_FRESH, ACT_DUP, ACT_EXTREME,
    ACT_BADJOB, ACT_NOISE
  } act_t;

  class reply_checker;
    logic [1:0]  mode;
    logic [7:0]  job_limit;
    logic [7:0]  chip_count;
    mrfc_pkg::phase_t count_phase;
    logic [31:0] prev_nonce;
    logic [7:0]  dup_run;
    reply_t      pending_replies[$];
    int          errors;

    function new();
      mode        = mrfc_pkg::MODE_RESET;
      job_limit   = mrfc_pkg::JOB_LIMIT_RESET;
      chip_count  = '0;
      count_phase = mrfc_pkg::PHASE_IDLE;
      prev_nonce  = '0;
      dup_run     = '0;
      errors      = 0;
    endfunction

    function logic [4:0] crc5(input logic [39:0] bits, input int count);
      logic [4:0] r;
      logic       fb;
      r = mrfc_pkg::CRC_INIT;
      for (int i = 0; i < count; i++) begin
        fb = r[4] ^ bits[39-i];
        r  = {r[3], r[2], r[1] ^ fb, r[0], fb};
      end
      return r;
    endfunction

    function void write_reg(input logic [mrfc_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [mrfc_pkg::CFG_DATA_W-1:0] data);
      if (idx == mrfc_pkg::CFG_MODE) begin
        mode = data[1:0];
      end else if (idx == mrfc_pkg::CFG_JOB_LIMIT) begin
        job_limit = data;
      end
    endfunction

    function void take_frame(input logic [39:0] f, input logic [2:0] len);
      int          n;
      logic [39:0] bytes;
      logic [7:0]  last;
      logic [31:0] nonce;
      logic [7:0]  job;
      reply_t      want;
      n     = (len > 5) ? 5 : int'(len);
      bytes = '0;
      for (int i = 0; i < n; i++) bytes[39-8*i -: 8] = f[39-8*i -: 8];
      want = '0;
      if (n == 0) begin
        if (mode == mrfc_pkg::MODE_COUNT && count_phase == mrfc_pkg::PHASE_SEEN) begin
          count_phase = mrfc_pkg::PHASE_DONE;
          want.kind   = mrfc_pkg::KIND_COUNT_DONE;
        end else begin
          want.kind = mrfc_pkg::KIND_IDLE;
        end
      end else begin
        last        = bytes[39-8*(n-1) -: 8];
        want.crc_ok = (last <= mrfc_pkg::CRC_MAX) && (crc5(bytes, 8*n-5) == last[4:0]);
        nonce       = bytes[39:8];
        job         = bytes[7:0] ^ mrfc_pkg::JOB_XOR;
        if (want.crc_ok) begin
          if (bytes[39:32] == mrfc_pkg::FREQ_REG) begin
            want.kind = mrfc_pkg::KIND_FREQ;
          end else if (mode == mrfc_pkg::MODE_COUNT && count_phase != mrfc_pkg::PHASE_DONE &&
                       bytes[39:32] == mrfc_pkg::CHIP_REPLY) begin
            if (chip_count != mrfc_pkg::COUNT_MAX) chip_count++;
            count_phase = mrfc_pkg::PHASE_SEEN;
            want.kind   = mrfc_pkg::KIND_CHIP;
          end else begin
            want.kind = mrfc_pkg::KIND_CMD;
          end
        end else if (mode == mrfc_pkg::MODE_MINING) begin
          if (nonce == '0 || nonce == mrfc_pkg::NONCE_ONES || job >= job_limit) begin
            want.kind = mrfc_pkg::KIND_IGNORED;
          end else if (nonce == prev_nonce) begin
            if (dup_run != mrfc_pkg::COUNT_MAX) dup_run++;
            want.first_dup = (dup_run == 8'd1);
            want.kind      = mrfc_pkg::KIND_DUP;
            want.nonce     = nonce;
            want.job       = job;
          end else begin
            dup_run    = '0;
            prev_nonce = nonce;
            want.kind  = mrfc_pkg::KIND_NONCE;
            want.nonce = nonce;
            want.job   = job;
          end
        end else begin
          want.kind = mrfc_pkg::KIND_IGNORED;
        end
      end
      want.total = chip_count;
      pending_replies.push_back(want);
    endfunction

    function void match_reply(input reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d nonce %h", got.kind, got.nonce);
        return;
      end
      want = pending_replies.pop_front();
      if (got.kind !== want.kind || got.crc_ok !== want.crc_ok ||
          got.nonce !== want.nonce || got.job !== want.job ||
          got.total !== want.total || got.first_dup !== want.first_dup) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected kind %0d crc %b nonce %h job %h total %0d dup %b,",
                    " got kind %0d crc %b nonce %h job %h total %0d dup %b"},
                   want.kind, want.crc_ok, want.nonce, want.job, want.total, want.first_dup,
                   got.kind, got.crc_ok, got.nonce, got.job, got.total, got.first_dup);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic [39:0] frame;
  logic [mrfc_pkg::LEN_W-1:0] frame_length;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [mrfc_pkg::KIND_W-1:0] kind;
  logic crc_ok;
  logic [31:0] nonce_value;
  logic [7:0] job_number;
  logic [7:0] chip_total;
  logic first_duplicate;
  logic cfg_valid;
  logic cfg_ready;
  logic [mrfc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mrfc_pkg::CFG_DATA_W-1:0] cfg_data;

  reply_checker sb;
  int stall_style;
  int gap_style;
  int burst_left;
  int stall_left = 0;
  logic stall_hold = 1'b0;
  int idle_cycles = 0;

  miner_response_frame_classifier_core u_dut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    case (stall_style)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 99) < 30);
      default: begin
        if (stall_left == 0) begin
          stall_hold = !stall_hold;
          stall_left = stall_hold ? $urandom_range(1, 30) : $urandom_range(1, 12);
        end
        stall_left = stall_left - 1;
        result_stall <= stall_hold;
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.match_reply({kind, crc_ok, nonce_value, job_number, chip_total, first_duplicate});
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [39:0] seal_crc(input logic [39:0] body, input int n);
    logic [39:0] f;
    f = body;
    for (int i = n - 1; i < 5; i++) f[39-8*i -: 8] = 8'h00;
    f[39-8*(n-1) -: 8] = {3'b000, sb.crc5(f, 8*n-5)};
    return f;
  endfunction

  function automatic logic [7:0] good_job();
    return 8'($urandom_range(0, int'(sb.job_limit) - 1));
  endfunction

  function automatic logic [7:0] bad_job();
    return 8'($urandom_range(int'(sb.job_limit), 255));
  endfunction

  function automatic act_t pick_action(input mix_t mix, input int roll);
    case (mix)
      MIX_CHIPS:
        return roll < 78 ? ACT_CHIP : roll < 84 ? ACT_FREQ : roll < 90 ? ACT_OTHER : ACT_NOISE;
      MIX_CHIPS_END:
        return roll < 40 ? ACT_CHIP : roll < 60 ? ACT_TIMEOUT : roll < 70 ? ACT_FREQ :
               roll < 80 ? ACT_OTHER : ACT_NOISE;
      MIX_MINING:
        return roll < 45 ? ACT_FRESH : roll < 65 ? ACT_DUP : roll < 70 ? ACT_EXTREME :
               roll < 75 ? ACT_BADJOB : roll < 78 ? ACT_CHIP : roll < 80 ? ACT_FREQ :
               roll < 83 ? ACT_OTHER : roll < 90 ? ACT_TIMEOUT : ACT_NOISE;
      MIX_DUPS:
        return roll < 97 ? ACT_DUP : ACT_EXTREME;
      default:
        return roll < 15 ? ACT_CHIP : roll < 25 ? ACT_FREQ : roll < 35 ? ACT_OTHER :
               roll < 48 ? ACT_TIMEOUT : roll < 63 ? ACT_FRESH : roll < 75 ? ACT_DUP :
               roll < 80 ? ACT_EXTREME : roll < 85 ? ACT_BADJOB : ACT_NOISE;
    endcase
  endfunction

  task automatic command_reply(input logic [7:0] head, input int shortest,
                               output logic [39:0] f, output logic [2:0] l);
    int n;
    n = $urandom_range(shortest, 5);
    f = seal_crc({head, 32'($urandom)}, n);
    l = 3'(n);
    if (n == 5 && $urandom_range(0, 3) == 0) l = 3'($urandom_range(6, 7));
  endtask

  task automatic nonce_reply(input logic [31:0] nonce, input logic [7:0] job,
                             output logic [39:0] f, output logic [2:0] l);
    f = {nonce, job ^ mrfc_pkg::JOB_XOR};
    l = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(6, 7)) : 3'd5;
  endtask

  task automatic pick_reply(input mix_t mix, output logic [39:0] f, output logic [2:0] l);
    int roll;
    roll = $urandom_range(0, 99);
    case (pick_action(mix, roll))
      ACT_CHIP:    command_reply(mrfc_pkg::CHIP_REPLY, 2, f, l);
      ACT_FREQ:    command_reply(mrfc_pkg::FREQ_REG, 2, f, l);
      ACT_OTHER:   command_reply(8'($urandom), 1, f, l);
      ACT_TIMEOUT: begin
        f = {32'($urandom), 8'($urandom)};
        l = 3'd0;
      end
      ACT_FRESH:   nonce_reply($urandom, good_job(), f, l);
      ACT_DUP:     nonce_reply(sb.prev_nonce, good_job(), f, l);
      ACT_EXTREME: nonce_reply(roll[0] ? mrfc_pkg::NONCE_ONES : 32'h0, good_job(), f, l);
      ACT_BADJOB:  nonce_reply($urandom, bad_job(), f, l);
      default: begin
        f = {32'($urandom), 8'($urandom)};
        l = 3'($urandom_range(mix == MIX_CHIPS ? 1 : 0, 7));
      end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_frame(input logic [39:0] f, input logic [2:0] l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case (gap_style)
        0: gap = 0;
        1: gap = $urandom_range(0, 3);
        default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      endcase
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_valid   <= 1'b1;
    frame        <= f;
    frame_length <= l;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.take_frame(f, l);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [mrfc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mrfc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // drop valid, let every result drain, then give the block time to go quiet
  task automatic settle();
    item_valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [1:0] m, input logic [7:0] lim, input mix_t mix,
                           input int items, input int stalls, input int gaps);
    logic [39:0] f;
    logic [2:0]  l;
    settle();
    write_reg(mrfc_pkg::CFG_MODE, 8'(m));
    write_reg(mrfc_pkg::CFG_JOB_LIMIT, lim);
    stall_style = stalls;
    gap_style   = gaps;
    repeat (items) begin
      pick_reply(mix, f, l);
      send_frame(f, l);
    end
  endtask

  task automatic directed_frames();
    // counting mode out of reset
    send_frame(40'h00_0000_0000, 3'd0);
    send_frame(40'hFF_FFFF_FFFF, 3'd0);
    send_frame(seal_crc(40'h13_A55A_0000, 5), 3'd5);
    send_frame(seal_crc(40'h80_1234_0000, 5), 3'd7);
    send_frame(seal_crc(40'h55_AA00_0000, 3), 3'd3);
    send_frame(seal_crc(40'h00_0000_0000, 1), 3'd1);
    send_frame(40'hFF_FFFF_FFFF, 3'd5);
    send_frame(40'h00_0000_0000, 3'd5);
    send_frame(seal_crc(40'h13_0000_0000, 5), 3'd6);
    send_frame(40'hFF_FFFF_FFFF, 3'd2);
    settle();
    write_reg(mrfc_pkg::CFG_MODE, 8'(mrfc_pkg::MODE_MINING));
    write_reg(mrfc_pkg::CFG_JOB_LIMIT, 8'd255);
    write_reg(CFG_SPARE_2, 8'hFF);
    write_reg(CFG_SPARE_3, 8'hA5);
    // mining: ignored nonces, a duplicate run, job limit edges, short frame, then a timeout and two sealed replies
    send_frame({32'h0000_0000, 8'h80}, 3'd5);
    send_frame({32'hFFFF_FFFF, 8'h81}, 3'd5);
    send_frame({32'h1234_5678, 8'h80}, 3'd5);
    send_frame({32'h1234_5678, 8'h80}, 3'd5);
    send_frame({32'h1234_5678, 8'h7E}, 3'd5);
    send_frame({32'hCAFE_0001, 8'h7E}, 3'd5);
    send_frame({32'hCAFE_0002, 8'h7F}, 3'd7);
    send_frame({32'hDEAD_BEEF, 8'h80}, 3'd3);
    send_frame(40'h00_0000_0000, 3'd0);
    send_frame(seal_crc(40'h80_0000_0000, 5), 3'd5);
    send_frame(seal_crc(40'h13_5500_0000, 4), 3'd4);
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    frame        = '0;
    frame_length = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    stall_style  = 1;
    gap_style    = 1;
    burst_left   = 0;
    sb           = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_frames();
    run_phase(mrfc_pkg::MODE_COUNT, 8'd31, MIX_CHIPS, 360, 0, 0);
    run_phase(mrfc_pkg::MODE_COUNT, 8'd31, MIX_CHIPS_END, 60, 1, 1);
    run_phase(mrfc_pkg::MODE_MINING, 8'd255, MIX_MINING, 330, 2, 2);
    run_phase(mrfc_pkg::MODE_MINING, 8'd1, MIX_DUPS, 280, 1, 0);
    run_phase(MODE_CLASSIFY, 8'($urandom_range(1, 255)), MIX_ANY, 240, 2, 1);
    run_phase(MODE_CLASSIFY_ALT, 8'($urandom_range(1, 255)), MIX_ANY, 150, 0, 2);
    run_phase(mrfc_pkg::MODE_COUNT, 8'd200, MIX_ANY, 200, 1, 1);
    run_phase(mrfc_pkg::MODE_MINING, 8'($urandom_range(1, 255)), MIX_MINING, 320, 1, 2);
    settle();

    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mrfc_pkg.sv
src/miner_response_frame_classifier_core.sv
tb/testbench.sv
